// ===== hdl/vt2ansi_pkg.sv =====
// ----------------------------------------------------------------------------
// vt2ansi_pkg
// Types, character codes and sequence-building helpers for the VT52-style
// escape to ANSI translator.
// ----------------------------------------------------------------------------
package vt2ansi_pkg;

	// Character and attribute codes
	localparam logic [7:0] CH_BEL       = 8'h07;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_CAN       = 8'h18;
	localparam logic [7:0] CH_ESC       = 8'h1B;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] ATTR_MODE    = 8'h77;
	localparam logic [7:0] ATTR_UNDERL  = 8'h01;
	localparam logic [7:0] ATTR_NORM    = 8'h07;
	localparam logic [7:0] ATTR_REVERSE = 8'h70;
	localparam logic [7:0] ATTR_INTENSE = 8'h08;
	localparam logic [7:0] ATTR_BLINK   = 8'h80;

	// Configuration register indexes and reset values
	localparam logic       REG_ROWS   = 1'b0;
	localparam logic       REG_COLS   = 1'b1;
	localparam logic [6:0] ROWS_RESET = 7'd25;
	localparam logic [6:0] COLS_RESET = 7'd80;
	localparam logic [6:0] LIMIT_MAX  = 7'd99;

	// Longest output sequence for one item
	localparam int MaxOut = 11;
	localparam int CntW   = $clog2(MaxOut + 1);

	typedef enum logic [2:0] {
		PS_GROUND = 3'd0,
		PS_ESC    = 3'd1,
		PS_ROW    = 3'd2,
		PS_COL    = 3'd3,
		PS_SKIP   = 3'd4
	} parser_state_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] byte_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       beep;
		logic       last;
	} out_item_t;

	// Bytes produced by one item, in transfer order
	typedef struct packed {
		logic [MaxOut-1:0][7:0] bytes;
		logic [MaxOut-1:0]      beep;
		logic [CntW-1:0]        cnt;
	} seq_t;

	// Append one byte; anything past the sequence length is dropped
	function automatic seq_t put_b(seq_t s, logic [7:0] c, logic bell);
		seq_t r;
		r = s;
		if (s.cnt < CntW'(MaxOut)) begin
			r.bytes[s.cnt] = c;
			r.beep[s.cnt]  = bell;
			r.cnt          = s.cnt + CntW'(1);
		end
		return r;
	endfunction

	function automatic seq_t put(seq_t s, logic [7:0] c);
		return put_b(s, c, 1'b0);
	endfunction

	function automatic seq_t put_csi(seq_t s);
		return put(put(s, CH_ESC), "[");
	endfunction

	// ESC [ H ESC [ 2 J
	function automatic seq_t put_clear(seq_t s);
		return put(put(put_csi(put(put_csi(s), "H")), "2"), "J");
	endfunction

	// Full SGR: ESC [ 0 [;7|;4] [;1] [;5] m
	function automatic seq_t put_sgr(seq_t s, logic [7:0] attr);
		seq_t r;
		r = put(put_csi(s), "0");
		if ((attr & ATTR_MODE) == ATTR_REVERSE) r = put(put(r, ";"), "7");
		if ((attr & ATTR_MODE) == ATTR_UNDERL)  r = put(put(r, ";"), "4");
		if ((attr & ATTR_INTENSE) != 8'h00)     r = put(put(r, ";"), "1");
		if ((attr & ATTR_BLINK) != 8'h00)       r = put(put(r, ";"), "5");
		return put(r, "m");
	endfunction

	// Byte as ground state sends it: bell beeps, newline becomes CR LF
	function automatic seq_t put_ground(seq_t s, logic [7:0] c);
		seq_t r;
		if (c == CH_BEL)     r = put_b(s, c, 1'b1);
		else if (c == CH_LF) r = put(put(s, CH_CR), CH_LF);
		else                 r = put(s, c);
		return r;
	endfunction

	// Decimal 1..99; tens by reciprocal multiply (exact below 180)
	function automatic seq_t put_dec(seq_t s, logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  ones;
		seq_t        r;
		prod = 15'(v) * 15'd205;
		tens = prod[14:11];
		ones = v - 7'(tens) * 7'd10;
		r    = s;
		if (v >= 7'd10) r = put(r, 8'h30 + 8'(tens));
		return put(r, 8'h30 + 8'(ones));
	endfunction

endpackage

// ===== hdl/vt52_escape_to_ansi_translator_top.sv =====
// ----------------------------------------------------------------------------
// vt52_escape_to_ansi_translator_top
// Translates VT52-style console escape sequences into ANSI byte sequences.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : item_valid/item_ready, payload item (mode, byte_in).
//                    mode = 1 is a warm reset of parser and attribute.
//   result channel : result_valid/result_ready, payload result
//                    (out_byte, beep, last); last marks an item's final byte.
//   config port    : wr_en/wr_index/wr_data, write only, no wait. Index 0 is
//                    screen_rows, index 1 screen_cols. Write only when idle.
// Path: an item waits in the input register, is translated there, and its
//   bytes are loaded into the result register once that register is free.
// Throughput: one item per cycle while each gives at most one byte and
//   result_ready stays high; an item that gives n bytes holds the result
//   register until its last byte is taken (one byte per cycle while
//   result_ready is high, up to eleven). Items that give nothing skip it.
// Stall: while the result side stalls, one further item is taken into the
//   input register; if it gives bytes, item_ready drops until bytes drain.
// Reset: parser to ground, attribute normal video, pending row zero, limits
//   25 rows and 80 columns, both stages empty.
// ----------------------------------------------------------------------------
module vt52_escape_to_ansi_translator_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  vt2ansi_pkg::in_item_t item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output vt2ansi_pkg::out_item_t result,
	input  logic                  wr_en,
	input  logic                  wr_index,
	input  logic [6:0]            wr_data
);

	// Configuration registers
	logic [6:0] rows_q, cols_q;

	// Translator state
	vt2ansi_pkg::parser_state_t state_q, state_nxt;
	logic [7:0]                 attr_q, attr_nxt;
	logic [7:0]                 pending_q, pending_nxt;

	// Input stage
	logic                  valid_s1;
	vt2ansi_pkg::in_item_t item_s1;
	logic                  adv_s1;

	// Result stage
	logic               valid_s2;
	vt2ansi_pkg::seq_t  seq_s2;
	logic [vt2ansi_pkg::CntW-1:0] idx_q;
	logic               last_byte, done_s2, free_s2;

	// Translation of the item in the input register
	vt2ansi_pkg::seq_t gen;
	logic [6:0]        lim_r, lim_c;
	logic [7:0]        row_off, col_off;
	logic              addr_ok;

	// --------------------------------------------------------------------
	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= vt2ansi_pkg::ROWS_RESET;
			cols_q <= vt2ansi_pkg::COLS_RESET;
		end else if (wr_en) begin
			if (wr_index == vt2ansi_pkg::REG_ROWS) rows_q <= wr_data;
			if (wr_index == vt2ansi_pkg::REG_COLS) cols_q <= wr_data;
		end
	end

	// Direct address range check
	assign lim_r   = (rows_q > vt2ansi_pkg::LIMIT_MAX) ? vt2ansi_pkg::LIMIT_MAX : rows_q;
	assign lim_c   = (cols_q > vt2ansi_pkg::LIMIT_MAX) ? vt2ansi_pkg::LIMIT_MAX : cols_q;
	assign row_off = pending_q - vt2ansi_pkg::CH_SPACE;
	assign col_off = item_s1.byte_in - vt2ansi_pkg::CH_SPACE;
	assign addr_ok = (pending_q >= vt2ansi_pkg::CH_SPACE)
		&& (item_s1.byte_in >= vt2ansi_pkg::CH_SPACE)
		&& (row_off < {1'b0, lim_r}) && (col_off < {1'b0, lim_c});

	// --------------------------------------------------------------------
	// Parser: next state, attribute and output sequence
	always_comb begin
		logic [7:0] c;
		c           = item_s1.byte_in;
		gen         = '0;
		state_nxt   = vt2ansi_pkg::PS_GROUND;
		attr_nxt    = attr_q;
		pending_nxt = pending_q;
		if (item_s1.mode) begin
			// warm reset
			if (attr_q != vt2ansi_pkg::ATTR_NORM) begin
				attr_nxt = vt2ansi_pkg::ATTR_NORM;
				gen      = vt2ansi_pkg::put_sgr(gen, vt2ansi_pkg::ATTR_NORM);
			end
		end else begin
			case (state_q)
				vt2ansi_pkg::PS_ESC: begin
					case (c) inside
						vt2ansi_pkg::CH_CAN: ;
						"A", "B", "C", "D":
							gen = vt2ansi_pkg::put(vt2ansi_pkg::put_csi(gen), c);
						"E": gen = vt2ansi_pkg::put_clear(gen);
						"H": gen = vt2ansi_pkg::put(vt2ansi_pkg::put_csi(gen), "H");
						"J": gen = vt2ansi_pkg::put(vt2ansi_pkg::put_csi(gen), "J");
						"K": gen = vt2ansi_pkg::put(vt2ansi_pkg::put_csi(gen), "K");
						"b": gen = vt2ansi_pkg::put(vt2ansi_pkg::put(
							vt2ansi_pkg::put_csi(gen), "1"), "J");
						"l": gen = vt2ansi_pkg::put(vt2ansi_pkg::put(
							vt2ansi_pkg::put_csi(gen), "2"), "K");
						"o": gen = vt2ansi_pkg::put(vt2ansi_pkg::put(
							vt2ansi_pkg::put_csi(gen), "1"), "K");
						"L": gen = vt2ansi_pkg::put(vt2ansi_pkg::put_csi(gen), "L");
						"M": gen = vt2ansi_pkg::put(vt2ansi_pkg::put_csi(gen), "M");
						"N": gen = vt2ansi_pkg::put(vt2ansi_pkg::put_csi(gen), "P");
						"j": gen = vt2ansi_pkg::put(
							vt2ansi_pkg::put(gen, vt2ansi_pkg::CH_ESC), "7");
						"k": gen = vt2ansi_pkg::put(
							vt2ansi_pkg::put(gen, vt2ansi_pkg::CH_ESC), "8");
						"p", "h", "q", "i": begin
							attr_nxt = attr_q & ~vt2ansi_pkg::ATTR_MODE;
							if (c == "p")      attr_nxt = attr_nxt | vt2ansi_pkg::ATTR_REVERSE;
							else if (c == "h") attr_nxt = attr_nxt | vt2ansi_pkg::ATTR_UNDERL;
							else               attr_nxt = attr_nxt | vt2ansi_pkg::ATTR_NORM;
							gen = vt2ansi_pkg::put_sgr(gen, attr_nxt);
						end
						"c", "d", "e", "f": begin
							if (c == "c")      attr_nxt = attr_q | vt2ansi_pkg::ATTR_BLINK;
							else if (c == "d") attr_nxt = attr_q & ~vt2ansi_pkg::ATTR_BLINK;
							else if (c == "e") attr_nxt = attr_q | vt2ansi_pkg::ATTR_INTENSE;
							else               attr_nxt = attr_q & ~vt2ansi_pkg::ATTR_INTENSE;
							gen = vt2ansi_pkg::put_sgr(gen, attr_nxt);
						end
						"z": begin
							attr_nxt = vt2ansi_pkg::ATTR_NORM;
							gen = vt2ansi_pkg::put_clear(
								vt2ansi_pkg::put_sgr(gen, vt2ansi_pkg::ATTR_NORM));
						end
						"Y", "=": state_nxt = vt2ansi_pkg::PS_ROW;
						"x", "y": state_nxt = vt2ansi_pkg::PS_SKIP;
						"@", "O", "F", "G", ">", "t", "u", "v", "w", "1", "2",
						"\\", "n", "Z", "(", ")", "3", "4": ;
						default: begin
							// unclaimed: ESC then the byte as ground sends it
							gen = vt2ansi_pkg::put_ground(
								vt2ansi_pkg::put(gen, vt2ansi_pkg::CH_ESC), c);
						end
					endcase
				end
				vt2ansi_pkg::PS_ROW: begin
					if (c != vt2ansi_pkg::CH_CAN) begin
						pending_nxt = c;
						state_nxt   = vt2ansi_pkg::PS_COL;
					end
				end
				vt2ansi_pkg::PS_COL: begin
					if (c != vt2ansi_pkg::CH_CAN && addr_ok) begin
						gen = vt2ansi_pkg::put_csi(gen);
						gen = vt2ansi_pkg::put_dec(gen, row_off[6:0] + 7'd1);
						gen = vt2ansi_pkg::put(gen, ";");
						gen = vt2ansi_pkg::put_dec(gen, col_off[6:0] + 7'd1);
						gen = vt2ansi_pkg::put(gen, "H");
					end
				end
				vt2ansi_pkg::PS_SKIP: ;
				default: begin
					if (c == vt2ansi_pkg::CH_ESC) state_nxt = vt2ansi_pkg::PS_ESC;
					else gen = vt2ansi_pkg::put_ground(gen, c);
				end
			endcase
		end
	end

	// --------------------------------------------------------------------
	// Handshake between stages
	assign last_byte  = (idx_q == seq_s2.cnt - vt2ansi_pkg::CntW'(1));
	assign done_s2    = valid_s2 && result_ready && last_byte;
	assign free_s2    = !valid_s2 || done_s2;
	// items that give no bytes move on without the result register
	assign adv_s1     = valid_s1 && (free_s2 || gen.cnt == '0);
	assign item_ready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// Translator state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= vt2ansi_pkg::PS_GROUND;
			attr_q    <= vt2ansi_pkg::ATTR_NORM;
			pending_q <= 8'h00;
		end else if (adv_s1) begin
			state_q   <= state_nxt;
			attr_q    <= attr_nxt;
			pending_q <= pending_nxt;
		end
	end

	// Result register and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (adv_s1 && gen.cnt != '0) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (done_s2) begin
			valid_s2 <= 1'b0;
		end else if (valid_s2 && result_ready) begin
			idx_q <= idx_q + vt2ansi_pkg::CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && gen.cnt != '0) begin
			seq_s2 <= gen;
		end
	end

	// Result port
	assign result_valid    = valid_s2;
	assign result.out_byte = seq_s2.bytes[idx_q];
	assign result.beep     = seq_s2.beep[idx_q];
	assign result.last     = last_byte;

	// --------------------------------------------------------------------
	// Assertions
	a_attr_mode: assert property (@(posedge clk) disable iff (!arst_n)
		((attr_q & vt2ansi_pkg::ATTR_MODE) == vt2ansi_pkg::ATTR_NORM)
		|| ((attr_q & vt2ansi_pkg::ATTR_MODE) == vt2ansi_pkg::ATTR_REVERSE)
		|| ((attr_q & vt2ansi_pkg::ATTR_MODE) == vt2ansi_pkg::ATTR_UNDERL))
		else $error("attribute mode field corrupt");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (idx_q < seq_s2.cnt))
		else $error("byte index beyond sequence length");

	a_beep_bell: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.beep) |-> (result.out_byte == vt2ansi_pkg::CH_BEL))
		else $error("beep on a byte that is not a bell");

	a_warm_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && item_s1.mode) |=>
		(attr_q == vt2ansi_pkg::ATTR_NORM && state_q == vt2ansi_pkg::PS_GROUND))
		else $error("warm reset left parser or attribute set");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Bench for the VT52-style escape to ANSI translator. A queue of console
// bytes and warm-reset items feeds a clocked driver; each transfer is
// translated by a behavioural copy of the parser and attribute logic, and
// the bytes it should give are queued. A clocked monitor compares every
// result transfer, field by field, with the oldest queued byte. The run
// steps through several row and column limits, the extremes among them,
// with random gaps and stalls on both sides in the first three phases.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	logic                   item_ready;
	vt2ansi_pkg::in_item_t  item = '0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	vt2ansi_pkg::out_item_t result;
	logic                   wr_en = 1'b0;
	logic                   wr_index = vt2ansi_pkg::REG_ROWS;
	logic [6:0]             wr_data = 7'd0;

	// Bench-side copy of the translator state and limits
	vt2ansi_pkg::parser_state_t prs = vt2ansi_pkg::PS_GROUND;
	logic [7:0]                 row_byte = 8'h00;
	logic [7:0]                 attr = vt2ansi_pkg::ATTR_NORM;
	logic [6:0]                 rows_lim = vt2ansi_pkg::ROWS_RESET;
	logic [6:0]                 cols_lim = vt2ansi_pkg::COLS_RESET;

	vt2ansi_pkg::in_item_t  pending_q[$];
	vt2ansi_pkg::out_item_t item_bytes[$];
	vt2ansi_pkg::out_item_t ansi_q[$];
	int        items_queued = 0;
	int        items_taken = 0;
	int        mismatches = 0;
	int        cycle_count = 0;
	int        send_gap_pct = 0;
	int        recv_stall_pct = 0;
	string     esc_cmds = "ABCDEHJKLMNbljkopqhicdefzY=xy@OFG>tuvw12\\nZ()34";

	vt52_escape_to_ansi_translator_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Translation of one item into the bytes it should give
	// ------------------------------------------------------------------
	function automatic void emit_ansi(logic [7:0] b, logic bell);
		vt2ansi_pkg::out_item_t o;
		if (item_bytes.size() < vt2ansi_pkg::MaxOut) begin
			o.out_byte = b;
			o.beep     = bell;
			o.last     = 1'b0;
			item_bytes.push_back(o);
		end
	endfunction

	function automatic void emit_csi();
		emit_ansi(vt2ansi_pkg::CH_ESC, 1'b0);
		emit_ansi("[", 1'b0);
	endfunction

	function automatic void emit_home_clear();
		emit_csi();
		emit_ansi("H", 1'b0);
		emit_csi();
		emit_ansi("2", 1'b0);
		emit_ansi("J", 1'b0);
	endfunction

	function automatic void emit_attr_sgr();
		emit_csi();
		emit_ansi("0", 1'b0);
		if ((attr & vt2ansi_pkg::ATTR_MODE) == vt2ansi_pkg::ATTR_REVERSE) begin
			emit_ansi(";", 1'b0);
			emit_ansi("7", 1'b0);
		end
		if ((attr & vt2ansi_pkg::ATTR_MODE) == vt2ansi_pkg::ATTR_UNDERL) begin
			emit_ansi(";", 1'b0);
			emit_ansi("4", 1'b0);
		end
		if ((attr & vt2ansi_pkg::ATTR_INTENSE) != 8'h00) begin
			emit_ansi(";", 1'b0);
			emit_ansi("1", 1'b0);
		end
		if ((attr & vt2ansi_pkg::ATTR_BLINK) != 8'h00) begin
			emit_ansi(";", 1'b0);
			emit_ansi("5", 1'b0);
		end
		emit_ansi("m", 1'b0);
	endfunction

	function automatic void set_video(logic [7:0] m);
		attr = (attr & ~vt2ansi_pkg::ATTR_MODE) | m;
		emit_attr_sgr();
	endfunction

	function automatic void set_flag(logic on, logic [7:0] bit_mask);
		attr = on ? (attr | bit_mask) : (attr & ~bit_mask);
		emit_attr_sgr();
	endfunction

	// Decimal 1..99, no leading zero
	function automatic void emit_number(logic [7:0] n);
		if (n >= 8'd10) emit_ansi(8'h30 + n / 8'd10, 1'b0);
		emit_ansi(8'h30 + n % 8'd10, 1'b0);
	endfunction

	// Ground-state byte: bell beeps, newline becomes CR LF
	function automatic void emit_plain(logic [7:0] c);
		if (c == vt2ansi_pkg::CH_BEL) begin
			emit_ansi(c, 1'b1);
		end else if (c == vt2ansi_pkg::CH_LF) begin
			emit_ansi(vt2ansi_pkg::CH_CR, 1'b0);
			emit_ansi(vt2ansi_pkg::CH_LF, 1'b0);
		end else begin
			emit_ansi(c, 1'b0);
		end
	endfunction

	// Register values above 99 behave as 99
	function automatic logic [7:0] addr_limit(logic [6:0] v);
		return (v > vt2ansi_pkg::LIMIT_MAX) ? {1'b0, vt2ansi_pkg::LIMIT_MAX} : {1'b0, v};
	endfunction

	function automatic void translate_item(vt2ansi_pkg::in_item_t it);
		logic [7:0]                 c;
		logic [7:0]                 r_off;
		logic [7:0]                 c_off;
		vt2ansi_pkg::parser_state_t was;
		c = it.byte_in;
		was = prs;
		item_bytes.delete();
		if (it.mode) begin
			// warm reset: back to normal video, parser to ground
			if (attr != vt2ansi_pkg::ATTR_NORM) begin
				attr = vt2ansi_pkg::ATTR_NORM;
				emit_attr_sgr();
			end
			prs = vt2ansi_pkg::PS_GROUND;
		end else begin
			prs = vt2ansi_pkg::PS_GROUND;
			case (was)
				vt2ansi_pkg::PS_ESC: begin
					case (c)
						vt2ansi_pkg::CH_CAN: ;
						"A", "B", "C", "D", "H", "J", "K", "L", "M": begin
							emit_csi();
							emit_ansi(c, 1'b0);
						end
						"N": begin
							emit_csi();
							emit_ansi("P", 1'b0);
						end
						"E": emit_home_clear();
						"b": begin
							emit_csi();
							emit_ansi("1", 1'b0);
							emit_ansi("J", 1'b0);
						end
						"l", "o": begin
							emit_csi();
							emit_ansi((c == "l") ? "2" : "1", 1'b0);
							emit_ansi("K", 1'b0);
						end
						"j", "k": begin
							emit_ansi(vt2ansi_pkg::CH_ESC, 1'b0);
							emit_ansi((c == "j") ? "7" : "8", 1'b0);
						end
						"p": set_video(vt2ansi_pkg::ATTR_REVERSE);
						"h": set_video(vt2ansi_pkg::ATTR_UNDERL);
						"q", "i": set_video(vt2ansi_pkg::ATTR_NORM);
						"c": set_flag(1'b1, vt2ansi_pkg::ATTR_BLINK);
						"d": set_flag(1'b0, vt2ansi_pkg::ATTR_BLINK);
						"e": set_flag(1'b1, vt2ansi_pkg::ATTR_INTENSE);
						"f": set_flag(1'b0, vt2ansi_pkg::ATTR_INTENSE);
						"z": begin
							attr = vt2ansi_pkg::ATTR_NORM;
							emit_attr_sgr();
							emit_home_clear();
						end
						"Y", "=": prs = vt2ansi_pkg::PS_ROW;
						"x", "y": prs = vt2ansi_pkg::PS_SKIP;
						"@", "O", "F", "G", ">", "t", "u", "v", "w", "1", "2",
						"\\", "n", "Z", "(", ")", "3", "4": ;
						default: begin
							// unclaimed escape: ESC, then the byte as a ground-state byte
							emit_ansi(vt2ansi_pkg::CH_ESC, 1'b0);
							emit_plain(c);
						end
					endcase
				end
				vt2ansi_pkg::PS_ROW: begin
					if (c != vt2ansi_pkg::CH_CAN) begin
						row_byte = c;
						prs = vt2ansi_pkg::PS_COL;
					end
				end
				vt2ansi_pkg::PS_COL: begin
					r_off = row_byte - vt2ansi_pkg::CH_SPACE;
					c_off = c - vt2ansi_pkg::CH_SPACE;
					if (c != vt2ansi_pkg::CH_CAN && row_byte >= vt2ansi_pkg::CH_SPACE &&
					    c >= vt2ansi_pkg::CH_SPACE &&
					    r_off < addr_limit(rows_lim) && c_off < addr_limit(cols_lim)) begin
						emit_csi();
						emit_number(r_off + 8'd1);
						emit_ansi(";", 1'b0);
						emit_number(c_off + 8'd1);
						emit_ansi("H", 1'b0);
					end
				end
				vt2ansi_pkg::PS_SKIP: ;
				default: begin
					if (c == vt2ansi_pkg::CH_ESC) prs = vt2ansi_pkg::PS_ESC;
					else emit_plain(c);
				end
			endcase
		end
		if (item_bytes.size() > 0) item_bytes[item_bytes.size() - 1].last = 1'b1;
		foreach (item_bytes[k]) ansi_q.push_back(item_bytes[k]);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus building
	// ------------------------------------------------------------------
	function automatic void queue_item(logic m, logic [7:0] b);
		vt2ansi_pkg::in_item_t it;
		it.mode    = m;
		it.byte_in = b;
		pending_q.push_back(it);
		items_queued++;
	endfunction

	// Row or column byte, weighted around the active limit
	function automatic logic [7:0] address_byte(logic [6:0] lim);
		logic [7:0] top;
		int         pick;
		top = addr_limit(lim);
		pick = $urandom_range(9, 0);
		case (pick)
			0: return vt2ansi_pkg::CH_CAN;
			1: return 8'($urandom_range(255, 0));
			2: return 8'($urandom_range(31, 0));
			3: return (top == 8'd0) ? vt2ansi_pkg::CH_SPACE
				: vt2ansi_pkg::CH_SPACE + top - 8'd1;
			4: return vt2ansi_pkg::CH_SPACE + top;
			default: return vt2ansi_pkg::CH_SPACE + 8'($urandom_range(int'(top) + 1, 0));
		endcase
	endfunction

	function automatic void queue_random(int n);
		int stop;
		int pick;
		stop = items_queued + n;
		while (items_queued < stop) begin
			pick = $urandom_range(99, 0);
			if (pick < 30) begin
				// claimed escape command
				queue_item(1'b0, vt2ansi_pkg::CH_ESC);
				if ($urandom_range(19, 0) == 0) queue_item(1'b0, vt2ansi_pkg::CH_CAN);
				else queue_item(1'b0, esc_cmds[$urandom_range(esc_cmds.len() - 1, 0)]);
			end else if (pick < 50) begin
				// direct cursor address
				queue_item(1'b0, vt2ansi_pkg::CH_ESC);
				queue_item(1'b0, $urandom_range(1, 0) ? "Y" : "=");
				queue_item(1'b0, address_byte(rows_lim));
				queue_item(1'b0, address_byte(cols_lim));
			end else if (pick < 58) begin
				// parameter escape eats one byte
				queue_item(1'b0, vt2ansi_pkg::CH_ESC);
				queue_item(1'b0, $urandom_range(1, 0) ? "x" : "y");
				queue_item(1'b0, 8'($urandom_range(255, 0)));
			end else if (pick < 68) begin
				// arbitrary byte after escape
				queue_item(1'b0, vt2ansi_pkg::CH_ESC);
				case ($urandom_range(3, 0))
					0: queue_item(1'b0, vt2ansi_pkg::CH_LF);
					1: queue_item(1'b0, vt2ansi_pkg::CH_BEL);
					default: queue_item(1'b0, 8'($urandom_range(255, 0)));
				endcase
			end else if (pick < 88) begin
				// plain console byte
				case ($urandom_range(5, 0))
					0: queue_item(1'b0, vt2ansi_pkg::CH_LF);
					1: queue_item(1'b0, vt2ansi_pkg::CH_BEL);
					2: queue_item(1'b0, vt2ansi_pkg::CH_CAN);
					default: queue_item(1'b0, 8'($urandom_range(255, 0)));
				endcase
			end else if (pick < 94) begin
				queue_item(1'b1, 8'($urandom_range(255, 0)));
			end else begin
				// broken sequence cut short by a warm reset
				queue_item(1'b0, vt2ansi_pkg::CH_ESC);
				if ($urandom_range(1, 0)) queue_item(1'b0, "Y");
				queue_item(1'b1, 8'($urandom_range(255, 0)));
			end
		end
	endfunction

	// Wait until every item is taken and every byte has come out
	task automatic settle();
		while (!(items_taken == items_queued && ansi_q.size() == 0)) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(logic idx, logic [6:0] val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en    <= 1'b0;
		if (idx == vt2ansi_pkg::REG_ROWS) rows_lim = val;
		else cols_lim = val;
	endtask

	// ------------------------------------------------------------------
	// Sequence of phases
	// ------------------------------------------------------------------
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 14;
		recv_stall_pct = 54;

		// directed: field extremes, attributes, warm reset, addressing
		queue_item(1'b0, "A");
		queue_item(1'b0, vt2ansi_pkg::CH_LF);
		queue_item(1'b0, vt2ansi_pkg::CH_BEL);
		queue_item(1'b0, 8'hFF);
		queue_item(1'b0, vt2ansi_pkg::CH_ESC);
		queue_item(1'b0, "p");
		queue_item(1'b0, vt2ansi_pkg::CH_ESC);
		queue_item(1'b0, "e");
		queue_item(1'b0, vt2ansi_pkg::CH_ESC);
		queue_item(1'b0, "c");
		queue_item(1'b1, 8'hFF);
		queue_item(1'b1, 8'h00);
		queue_item(1'b0, vt2ansi_pkg::CH_ESC);
		queue_item(1'b0, "Y");
		queue_item(1'b0, vt2ansi_pkg::CH_SPACE + 8'd24);
		queue_item(1'b0, vt2ansi_pkg::CH_SPACE + 8'd79);
		queue_item(1'b0, vt2ansi_pkg::CH_ESC);
		queue_item(1'b0, "=");
		queue_item(1'b0, vt2ansi_pkg::CH_SPACE + 8'd25);
		queue_item(1'b0, vt2ansi_pkg::CH_SPACE);
		queue_item(1'b0, vt2ansi_pkg::CH_ESC);
		queue_item(1'b0, vt2ansi_pkg::CH_BEL);
		queue_item(1'b0, vt2ansi_pkg::CH_ESC);
		queue_item(1'b0, "z");
		queue_random(60);
		settle();

		set_limit(vt2ansi_pkg::REG_ROWS, 7'd99);
		set_limit(vt2ansi_pkg::REG_COLS, 7'd99);
		queue_random(50);
		settle();

		send_gap_pct = 54;
		recv_stall_pct = 14;
		set_limit(vt2ansi_pkg::REG_ROWS, 7'd1);
		set_limit(vt2ansi_pkg::REG_COLS, 7'd127);
		queue_random(50);
		settle();

		send_gap_pct = 0;
		recv_stall_pct = 0;
		set_limit(vt2ansi_pkg::REG_ROWS, 7'd0);
		set_limit(vt2ansi_pkg::REG_COLS, 7'd1);
		queue_random(30);
		settle();

		set_limit(vt2ansi_pkg::REG_ROWS, 7'd127);
		set_limit(vt2ansi_pkg::REG_COLS, 7'd0);
		queue_random(30);
		settle();

		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// Driver: predicts on each item transfer, then offers the next item
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) begin
				translate_item(item);
				items_taken++;
			end
			if (!item_valid || item_ready) begin
				if (pending_q.size() > 0 && $urandom_range(99, 0) >= send_gap_pct) begin
					item       <= pending_q.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each result transfer against the oldest byte due
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		vt2ansi_pkg::out_item_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (ansi_q.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %h",
					         $time, result);
					mismatches++;
				end else begin
					want = ansi_q.pop_front();
					if (result.out_byte !== want.out_byte) begin
						$display("%0t: out_byte expected %h actual %h",
						         $time, want.out_byte, result.out_byte);
						mismatches++;
					end
					if (result.beep !== want.beep) begin
						$display("%0t: beep expected %b actual %b",
						         $time, want.beep, result.beep);
						mismatches++;
					end
					if (result.last !== want.last) begin
						$display("%0t: last expected %b actual %b",
						         $time, want.last, result.last);
						mismatches++;
					end
				end
			end
			result_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
hdl/vt2ansi_pkg.sv
hdl/vt52_escape_to_ansi_translator_top.sv
bench/tb.sv
